[rtl/core/cfc_pkg.sv]
// Shared types, character codes, verdict codes and helper functions for the
// command frame checker. Has no dependencies of its own.
`timescale 1ns / 1ps

package cfc_pkg;

    // Default build-time limits.
    localparam int unsigned PAYLOAD_LIMIT_DEF = 96;
    localparam int unsigned MAX_ARGS_DEF      = 8;

    // Fixed field widths.
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned VERDICT_W = 3;
    localparam int unsigned SEQ_W     = 16;
    localparam int unsigned ARG_W     = 4;
    localparam int unsigned PHASE_W   = 2;

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_MARKER = 8'h3E;  // '>'
    localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
    localparam logic [7:0] CH_COMMA  = 8'h2C;  // ','
    localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
    localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE   = 8'h39;  // '9'

    // CRC-8 generator polynomial and top bit.
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    // Sequence magnitude limits.
    localparam logic [15:0] SEQ_MAG_SAT = 16'h8000;
    localparam logic [15:0] SEQ_POS_MAX = 16'h7FFF;

    // Verdict codes.
    localparam logic [2:0] VERDICT_OK       = 3'd0;
    localparam logic [2:0] VERDICT_MARKER   = 3'd1;
    localparam logic [2:0] VERDICT_NO_STAR  = 3'd2;
    localparam logic [2:0] VERDICT_CRC      = 3'd3;
    localparam logic [2:0] VERDICT_TOO_LONG = 3'd4;
    localparam logic [2:0] VERDICT_FIELDS   = 3'd5;

    // Sequence token parse phases.
    localparam logic [1:0] PHASE_LEAD   = 2'd0;
    localparam logic [1:0] PHASE_DIGITS = 2'd1;
    localparam logic [1:0] PHASE_DONE   = 2'd2;

    // One input transaction: a byte of the line and the last-byte flag.
    typedef struct packed {
        logic [7:0] char_byte;
        logic       line_end;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic [2:0]         verdict;
        logic signed [15:0] seq_number;
        logic [3:0]         arg_count;
        logic [7:0]         computed_crc;
    } t_out_item;

    // Blank characters as the C library defines them.
    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            res = {1'b1, 4'(c - 8'h30)};
        end else if ((c >= 8'h61) && (c <= 8'h66)) begin
            res = {1'b1, 4'(c - 8'h57)};
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            res = {1'b1, 4'(c - 8'h37)};
        end
        return res;
    endfunction

    // CRC-8 update for one byte, MSB first, no reflection.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] c);
        logic [7:0] v;
        v = crc ^ c;
        for (int i = 0; i < 8; i++) begin
            if ((v & CRC_TOP) != 8'h00) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

[rtl/core/command_frame_checker.sv]
// Top level of the command frame checker: input register, per-byte frame
// state update and result register. Depends on cfc_pkg.
`timescale 1ns / 1ps

// Checks text command lines of the form ">SEQ,NAME,arg,...*HH" fed one byte
// per transaction, with line_end set on the final byte. The block takes one
// byte every clock cycle for as long as the result side keeps up; a line's
// result passes from the input register through the combinational per-byte
// update (CRC-8 over the byte, token and sequence parsing, hex capture) into
// the result register, which loads when the last byte advances. Bytes other
// than the last give no result. A waiting result does not hold up bytes of the
// next line; only a second last byte stalls while the previous result is still
// untaken. The verdict reports the first failing check: bad marker, no star,
// CRC mismatch, payload too long, too few tokens.
module command_frame_checker #(
    parameter int unsigned PAYLOAD_LIMIT = cfc_pkg::PAYLOAD_LIMIT_DEF,
    parameter int unsigned MAX_ARGS      = cfc_pkg::MAX_ARGS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  cfc_pkg::t_in_item i_in_data,
    output logic              o_in_stall,
    output logic               o_out_valid,
    output cfc_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);

    localparam int unsigned TOKEN_CAP = MAX_ARGS + 2;
    localparam int unsigned TOK_W     = $clog2(TOKEN_CAP + 1);

    // Input register.
    logic              r_in_valid;
    cfc_pkg::t_in_item r_in;

    // Frame state.
    logic             r_first, n_first;
    logic             r_marker_ok, n_marker_ok;
    logic             r_str_end, n_str_end;
    logic [7:0]       r_crc, n_crc;
    logic [7:0]       r_len, n_len;
    logic [TOK_W-1:0] r_tok, n_tok;
    logic             r_inside, n_inside;
    logic [16:0]      r_seq, n_seq;
    logic [1:0]       r_phase, n_phase;
    logic             r_star_seen, n_star_seen;
    logic [7:0]       r_snap_crc, n_snap_crc;
    logic [7:0]       r_snap_len, n_snap_len;
    logic [TOK_W-1:0] r_snap_tok, n_snap_tok;
    logic [16:0]      r_snap_seq, n_snap_seq;
    logic [7:0]       r_hex, n_hex;
    logic             r_hex_done, n_hex_done;
    logic             r_hex_started, n_hex_started;

    // Result register.
    logic               r_out_valid;
    cfc_pkg::t_out_item r_out;
    cfc_pkg::t_out_item n_out;

    logic out_free;
    logic advance;

    logic [7:0]  c;
    logic [4:0]  hex_d;
    logic        is_digit;
    logic        take_digit;
    logic [19:0] mag10;
    logic [15:0] mag_sat;
    logic [TOK_W-1:0] extra;

    // Handshake: the held byte moves on unless it would close a line while
    // the previous result is still waiting.
    assign out_free    = !r_out_valid || !i_out_stall;
    assign advance     = r_in_valid && (!r_in.line_end || out_free);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign c        = r_in.char_byte;
    assign hex_d    = cfc_pkg::hex_value(c);
    assign is_digit = (c >= cfc_pkg::CH_ZERO) && (c <= cfc_pkg::CH_NINE);

    // Decimal accumulate with saturation of the magnitude.
    assign mag10   = ({4'd0, r_seq[15:0]} << 3) + ({4'd0, r_seq[15:0]} << 1)
                     + {16'd0, 4'(c - cfc_pkg::CH_ZERO)};
    assign mag_sat = (mag10 > {4'd0, cfc_pkg::SEQ_MAG_SAT}) ? cfc_pkg::SEQ_MAG_SAT
                                                            : mag10[15:0];

    // Per-byte update of the frame state.
    always_comb begin
        n_first       = r_first;
        n_marker_ok   = r_marker_ok;
        n_str_end     = r_str_end;
        n_crc         = r_crc;
        n_len         = r_len;
        n_tok         = r_tok;
        n_inside      = r_inside;
        n_seq         = r_seq;
        n_phase       = r_phase;
        n_star_seen   = r_star_seen;
        n_snap_crc    = r_snap_crc;
        n_snap_len    = r_snap_len;
        n_snap_tok    = r_snap_tok;
        n_snap_seq    = r_snap_seq;
        n_hex         = r_hex;
        n_hex_done    = r_hex_done;
        n_hex_started = r_hex_started;
        take_digit    = 1'b0;

        if (r_first) begin
            n_first     = 1'b0;
            n_marker_ok = (c == cfc_pkg::CH_MARKER);
        end else if (r_marker_ok && !r_str_end) begin
            if (c == cfc_pkg::CH_NUL) begin
                n_str_end = 1'b1;
            end else begin
                // A star snapshots the payload figures and restarts the hex field.
                if (c == cfc_pkg::CH_STAR) begin
                    n_star_seen   = 1'b1;
                    n_snap_crc    = r_crc;
                    n_snap_len    = r_len;
                    n_snap_tok    = r_tok;
                    n_snap_seq    = r_seq;
                    n_hex         = 8'd0;
                    n_hex_done    = 1'b0;
                    n_hex_started = 1'b0;
                end else if (r_star_seen && !r_hex_done) begin
                    if (hex_d[4]) begin
                        n_hex         = {r_hex[3:0], hex_d[3:0]};
                        n_hex_started = 1'b1;
                    end else if (r_hex_started || !cfc_pkg::is_blank(c)) begin
                        n_hex_done = 1'b1;
                    end
                end

                // Running figures keep going after a star.
                n_crc = cfc_pkg::crc8_byte(r_crc, c);
                if (r_len != 8'hFF) begin
                    n_len = r_len + 8'd1;
                end

                // Token counting and parsing of the first token.
                if (c == cfc_pkg::CH_COMMA) begin
                    n_inside = 1'b0;
                end else begin
                    if (!r_inside) begin
                        n_inside = 1'b1;
                        if (r_tok < TOK_W'(TOKEN_CAP)) begin
                            n_tok = r_tok + TOK_W'(1);
                        end
                    end
                    if (n_tok == TOK_W'(1)) begin
                        case (r_phase)
                            cfc_pkg::PHASE_LEAD: begin
                                if (cfc_pkg::is_blank(c)) begin
                                    n_phase = r_phase;
                                end else if (c == cfc_pkg::CH_PLUS) begin
                                    n_phase = cfc_pkg::PHASE_DIGITS;
                                end else if (c == cfc_pkg::CH_MINUS) begin
                                    n_seq   = 17'h10000;
                                    n_phase = cfc_pkg::PHASE_DIGITS;
                                end else if (!is_digit) begin
                                    n_phase = cfc_pkg::PHASE_DONE;
                                end else begin
                                    n_phase    = cfc_pkg::PHASE_DIGITS;
                                    take_digit = 1'b1;
                                end
                            end
                            cfc_pkg::PHASE_DIGITS: begin
                                if (!is_digit) begin
                                    n_phase = cfc_pkg::PHASE_DONE;
                                end else begin
                                    take_digit = 1'b1;
                                end
                            end
                            default: begin
                                n_phase = r_phase;
                            end
                        endcase
                        if (take_digit) begin
                            n_seq = {r_seq[16], mag_sat};
                        end
                    end
                end
            end
        end
    end

    // Verdict from the state that includes the current byte.
    assign extra = n_snap_tok - TOK_W'(2);

    always_comb begin
        n_out.verdict      = cfc_pkg::VERDICT_OK;
        n_out.seq_number   = 16'sd0;
        n_out.arg_count    = 4'd0;
        n_out.computed_crc = 8'd0;
        if (!n_marker_ok) begin
            n_out.verdict = cfc_pkg::VERDICT_MARKER;
        end else if (!n_star_seen) begin
            n_out.verdict = cfc_pkg::VERDICT_NO_STAR;
        end else begin
            n_out.computed_crc = n_snap_crc;
            if (n_snap_crc != n_hex) begin
                n_out.verdict = cfc_pkg::VERDICT_CRC;
            end else if (n_snap_len >= 8'(PAYLOAD_LIMIT)) begin
                n_out.verdict = cfc_pkg::VERDICT_TOO_LONG;
            end else if (n_snap_tok < TOK_W'(2)) begin
                n_out.verdict = cfc_pkg::VERDICT_FIELDS;
            end else begin
                if (n_snap_seq[16]) begin
                    n_out.seq_number = 16'(16'd0 - n_snap_seq[15:0]);
                end else if (n_snap_seq[15:0] > cfc_pkg::SEQ_POS_MAX) begin
                    n_out.seq_number = cfc_pkg::SEQ_POS_MAX;
                end else begin
                    n_out.seq_number = n_snap_seq[15:0];
                end
                if (extra > TOK_W'(MAX_ARGS)) begin
                    n_out.arg_count = 4'(MAX_ARGS);
                end else begin
                    n_out.arg_count = 4'(extra);
                end
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Frame state: a last byte returns everything to its reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_in.line_end)) begin
            r_first       <= 1'b1;
            r_marker_ok   <= 1'b0;
            r_str_end     <= 1'b0;
            r_crc         <= 8'd0;
            r_len         <= 8'd0;
            r_tok         <= '0;
            r_inside      <= 1'b0;
            r_seq         <= 17'd0;
            r_phase       <= cfc_pkg::PHASE_LEAD;
            r_star_seen   <= 1'b0;
            r_snap_crc    <= 8'd0;
            r_snap_len    <= 8'd0;
            r_snap_tok    <= '0;
            r_snap_seq    <= 17'd0;
            r_hex         <= 8'd0;
            r_hex_done    <= 1'b0;
            r_hex_started <= 1'b0;
        end else if (advance) begin
            r_first       <= n_first;
            r_marker_ok   <= n_marker_ok;
            r_str_end     <= n_str_end;
            r_crc         <= n_crc;
            r_len         <= n_len;
            r_tok         <= n_tok;
            r_inside      <= n_inside;
            r_seq         <= n_seq;
            r_phase       <= n_phase;
            r_star_seen   <= n_star_seen;
            r_snap_crc    <= n_snap_crc;
            r_snap_len    <= n_snap_len;
            r_snap_tok    <= n_snap_tok;
            r_snap_seq    <= n_snap_seq;
            r_hex         <= n_hex;
            r_hex_done    <= n_hex_done;
            r_hex_started <= n_hex_started;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in.line_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in.line_end) begin
            r_out <= n_out;
        end
    end

endmodule
